>>> src/rcth_pkg.sv
// Shared types and constants for the row c-transform hull engine.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none
package rcth_pkg;

   localparam int MAX_ROW     = 64;
   localparam int FRAC_BITS   = 16;
   localparam int DATA_W      = 32;
   localparam int IDX_W       = $clog2(MAX_ROW);
   localparam int LEN_W       = IDX_W + 1;
   localparam int M_W         = 2 * LEN_W;
   localparam int Q_W         = FRAC_BITS + 1;
   localparam int NUM_W       = M_W + FRAC_BITS + 1;
   localparam int NSQ_W       = 2 * LEN_W - 1;
   localparam int DEN_W       = NSQ_W + 2;
   localparam int PROD_W      = DATA_W + NSQ_W + 3;
   localparam int QUEUE_DEPTH = 4;
   localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

   localparam logic [LEN_W-1:0] ROW_LEN_RESET = LEN_W'(MAX_ROW);
   localparam logic [LEN_W-1:0] ROW_LEN_MIN   = LEN_W'(2);

   typedef struct packed {
      logic [DATA_W-1:0] sample;
      logic [IDX_W-1:0]  idx;
      logic              last;
      logic [LEN_W-1:0]  len;
   } word_type;

   typedef struct packed {
      logic [IDX_W-1:0]         idx;
      logic signed [DATA_W-1:0] val;
   } vertex_type;

   typedef enum logic [4:0] {
      B_IDLE, B_R0, B_R1, B_R2, B_RD, B_LD, B_MUL, B_CMP, B_POP,
      B_W0, B_W1, B_W2, B_CHK, B_WCMP, B_ADV, B_TM, B_TG, B_TW
   } back_state_type;

   function automatic logic signed [DATA_W:0] sdiff(input logic signed [DATA_W-1:0] a,
                                                   input logic signed [DATA_W-1:0] b);
      logic signed [DATA_W:0] ae;
      logic signed [DATA_W:0] be;
      ae = (DATA_W+1)'(a);
      be = (DATA_W+1)'(b);
      return ae - be;
   endfunction

endpackage
`default_nettype wire

>>> src/rcth_front.sv
// Front end: takes samples, holds the row length register, tags each word
// with its index, last flag and length. Depends on rcth_pkg.
`timescale 1ns / 1ps
`default_nettype none
module rcth_front import rcth_pkg::*; (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              start,
   input  wire logic [DATA_W-1:0] req_sample,
   input  wire logic              csr_we,
   input  wire logic [LEN_W-1:0]  csr_wdata,
   input  wire logic              q_full,
   output logic                   busy,
   output logic                   push,
   output word_type               word
);

   logic [LEN_W-1:0] row_length_ff, row_length_in;
   logic [LEN_W-1:0] load_count_ff, load_count_in;
   logic [LEN_W-1:0] len;
   logic [LEN_W-1:0] idx;
   logic             last;

   always_comb begin
      if (row_length_ff < ROW_LEN_MIN) begin
         len = ROW_LEN_MIN;
      end else if (row_length_ff > LEN_W'(MAX_ROW)) begin
         len = LEN_W'(MAX_ROW);
      end else begin
         len = row_length_ff;
      end
      idx  = (load_count_ff >= len) ? '0 : load_count_ff;
      last = ((idx + LEN_W'(1)) == len);
      busy = q_full;
      push = start & ~q_full;
      word.sample = req_sample;
      word.idx    = idx[IDX_W-1:0];
      word.last   = last;
      word.len    = len;
      row_length_in = csr_we ? csr_wdata : row_length_ff;
      load_count_in = load_count_ff;
      if (csr_we) begin
         load_count_in = '0;
      end else if (push) begin
         load_count_in = last ? '0 : idx + LEN_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         row_length_ff <= ROW_LEN_RESET;
         load_count_ff <= '0;
      end else begin
         row_length_ff <= row_length_in;
         load_count_ff <= load_count_in;
      end
   end

endmodule
`default_nettype wire

>>> src/rcth_queue.sv
// Short word queue between the front end and the back end.
// Depends on rcth_pkg.
`timescale 1ns / 1ps
`default_nettype none
module rcth_queue import rcth_pkg::*; (
   input  wire logic     clock,
   input  wire logic     reset,
   input  wire logic     push,
   input  word_type      push_word,
   input  wire logic     pop,
   output word_type      head,
   output logic          empty,
   output logic          full
);

   word_type             slot_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0]    wr_ff, wr_in;
   logic [QPTR_W-1:0]    rd_ff, rd_in;
   logic [QPTR_W:0]      count_ff, count_in;

   always_comb begin
      empty    = (count_ff == '0);
      full     = (count_ff == (QPTR_W+1)'(QUEUE_DEPTH));
      head     = slot_ff[rd_ff];
      wr_in    = push ? wr_ff + QPTR_W'(1) : wr_ff;
      rd_in    = pop ? rd_ff + QPTR_W'(1) : rd_ff;
      count_in = count_ff + (QPTR_W+1)'(push) - (QPTR_W+1)'(pop);
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ff] <= push_word;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff    <= '0;
         rd_ff    <= '0;
         count_ff <= '0;
      end else begin
         wr_ff    <= wr_in;
         rd_ff    <= rd_in;
         count_ff <= count_in;
      end
   end

endmodule
`default_nettype wire

>>> src/rcth_div.sv
// Restoring divider, one quotient bit per cycle, for the rounded grid products.
// Depends on rcth_pkg.
`timescale 1ns / 1ps
`default_nettype none
module rcth_div import rcth_pkg::*; (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             go,
   input  wire logic [NUM_W-1:0] num,
   input  wire logic [DEN_W-1:0] den,
   output logic                  done,
   output logic [Q_W-1:0]        quot
);

   localparam int CNT_W = $clog2(Q_W + 1);

   logic [DEN_W-1:0] rem_ff, rem_in;
   logic [Q_W-1:0]   sh_ff, sh_in;
   logic [Q_W-1:0]   quot_ff, quot_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic             run_ff, run_in;
   logic             done_ff, done_in;
   logic [DEN_W:0]   trial;
   logic             ge;

   always_comb begin
      trial   = {rem_ff, sh_ff[Q_W-1]};
      ge      = (trial >= {1'b0, den});
      rem_in  = rem_ff;
      sh_in   = sh_ff;
      quot_in = quot_ff;
      cnt_in  = cnt_ff;
      run_in  = run_ff;
      done_in = 1'b0;
      if (go) begin
         rem_in = DEN_W'(num[NUM_W-1:Q_W]);
         sh_in  = num[Q_W-1:0];
         cnt_in = CNT_W'(Q_W);
         run_in = 1'b1;
      end else if (run_ff) begin
         rem_in  = ge ? DEN_W'(trial - {1'b0, den}) : DEN_W'(trial);
         sh_in   = {sh_ff[Q_W-2:0], 1'b0};
         quot_in = {quot_ff[Q_W-2:0], ge};
         cnt_in  = cnt_ff - CNT_W'(1);
         if (cnt_ff == CNT_W'(1)) begin
            run_in  = 1'b0;
            done_in = 1'b1;
         end
      end
      done = done_ff;
      quot = quot_ff;
   end

   always_ff @(posedge clock) begin
      rem_ff  <= rem_in;
      sh_ff   <= sh_in;
      quot_ff <= quot_in;
      cnt_ff  <= cnt_in;
      if (reset) begin
         run_ff  <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         run_ff  <= run_in;
         done_ff <= done_in;
      end
   end

endmodule
`default_nettype wire

>>> src/rcth_back.sv
// Back end: stores the row, builds the lower hull on a stack, walks the grid
// and emits one result per point. Depends on rcth_pkg and rcth_div.
`timescale 1ns / 1ps
`default_nettype none
module rcth_back import rcth_pkg::*; (
   input  wire logic               clock,
   input  wire logic               reset,
   input  word_type                head,
   input  wire logic               empty,
   output logic                    pop,
   output logic                    rsp_valid,
   output logic [DATA_W-1:0]       rsp_dual_value,
   output logic [IDX_W-1:0]        rsp_matching_index,
   output logic                    rsp_last_of_row
);

   back_state_type           state_ff, state_in;
   logic [LEN_W-1:0]         n_ff, n_in;
   logic [NSQ_W-1:0]         nsq_ff, nsq_in;
   logic [LEN_W-1:0]         i_ff, i_in;
   logic [LEN_W-1:0]         p_ff, p_in;
   logic [LEN_W-1:0]         size_ff, size_in;
   vertex_type               sec_ff, sec_in, top_ff, top_in;
   vertex_type               a_ff, a_in, b_ff, b_in;
   logic signed [DATA_W-1:0] bval_ff, bval_in;
   logic signed [DATA_W-1:0] un1_ff, un1_in;
   logic signed [PROD_W-1:0] lhs_ff, lhs_in, rhs_ff, rhs_in;
   logic [M_W-1:0]           m_ff, m_in;
   logic                     second_ff, second_in;
   logic signed [DATA_W+1:0] v1_ff, v1_in;
   logic                     valid_ff, valid_in;
   logic [DATA_W-1:0]        value_ff, value_in;
   logic [IDX_W-1:0]         index_ff, index_in;
   logic                     last_ff, last_in;

   logic [DATA_W-1:0]        smem [MAX_ROW];
   logic                     s_we;
   logic [IDX_W-1:0]         s_waddr, s_raddr;
   logic [DATA_W-1:0]        s_wdata, s_rdata_ff;
   vertex_type               kmem [MAX_ROW];
   logic                     k_we;
   logic [IDX_W-1:0]         k_waddr, k_raddr;
   vertex_type               k_wdata, k_rdata_ff;

   logic                     div_go, div_done;
   logic [NUM_W-1:0]         div_num;
   logic [DEN_W-1:0]         div_den;
   logic [Q_W-1:0]           div_q;

   logic signed [DATA_W:0]   op_a, op_c;
   logic signed [M_W:0]      op_b, op_d;
   logic [LEN_W-1:0]         n_m1;
   logic [M_W-1:0]           odd_i, odd_k;
   logic signed [DATA_W+1:0] vq, vs, v2, vsel;
   vertex_type               cand;

   rcth_div u_div (
      .clock (clock),
      .reset (reset),
      .go    (div_go),
      .num   (div_num),
      .den   (div_den),
      .done  (div_done),
      .quot  (div_q)
   );

   always_comb begin
      state_in  = state_ff;
      n_in      = n_ff;
      nsq_in    = nsq_ff;
      i_in      = i_ff;
      p_in      = p_ff;
      size_in   = size_ff;
      sec_in    = sec_ff;
      top_in    = top_ff;
      a_in      = a_ff;
      b_in      = b_ff;
      bval_in   = bval_ff;
      un1_in    = un1_ff;
      lhs_in    = lhs_ff;
      rhs_in    = rhs_ff;
      m_in      = m_ff;
      second_in = second_ff;
      v1_in     = v1_ff;
      valid_in  = 1'b0;
      value_in  = value_ff;
      index_in  = index_ff;
      last_in   = last_ff;
      pop       = 1'b0;
      s_we      = 1'b0;
      s_waddr   = head.idx;
      s_wdata   = head.sample;
      s_raddr   = '0;
      k_we      = 1'b0;
      k_waddr   = '0;
      k_wdata   = '0;
      k_raddr   = '0;
      div_go    = 1'b0;
      n_m1      = n_ff - LEN_W'(1);
      cand.idx  = i_ff[IDX_W-1:0];
      cand.val  = bval_ff;
      div_num   = NUM_W'({m_ff, {FRAC_BITS{1'b0}}}) + NUM_W'({nsq_ff, 1'b0});
      div_den   = {nsq_ff, 2'b00};
      op_a      = '0;
      op_b      = '0;
      op_c      = '0;
      op_d      = '0;
      odd_i     = M_W'({i_ff[IDX_W-1:0], 1'b1});
      odd_k     = second_ff ? M_W'({n_m1[IDX_W-1:0], 1'b1}) : M_W'({a_ff.idx, 1'b1});
      vq        = (DATA_W+2)'(div_q);
      vs        = second_ff ? (DATA_W+2)'(un1_ff) : (DATA_W+2)'(a_ff.val);
      v2        = vq - vs;
      vsel      = v2;

      unique case (state_ff)
         B_IDLE: begin
            if (!empty) begin
               pop  = 1'b1;
               s_we = 1'b1;
               if (head.last) begin
                  n_in     = head.len;
                  nsq_in   = NSQ_W'(head.len) * NSQ_W'(head.len);
                  state_in = B_R0;
               end
            end
         end
         B_R0: begin
            s_raddr  = '0;
            state_in = B_R1;
         end
         B_R1: begin
            sec_in.idx = '0;
            sec_in.val = s_rdata_ff;
            k_we       = 1'b1;
            k_waddr    = '0;
            k_wdata    = sec_in;
            s_raddr    = IDX_W'(1);
            state_in   = B_R2;
         end
         B_R2: begin
            top_in.idx = IDX_W'(1);
            top_in.val = s_rdata_ff;
            k_we       = 1'b1;
            k_waddr    = IDX_W'(1);
            k_wdata    = top_in;
            size_in    = LEN_W'(2);
            i_in       = LEN_W'(2);
            state_in   = (n_ff == LEN_W'(2)) ? B_W0 : B_RD;
         end
         B_RD: begin
            s_raddr  = i_ff[IDX_W-1:0];
            state_in = B_LD;
         end
         B_LD: begin
            bval_in  = s_rdata_ff;
            state_in = B_MUL;
         end
         B_MUL: begin
            op_a     = sdiff(bval_ff, top_ff.val);
            op_b     = (M_W+1)'(top_ff.idx - sec_ff.idx);
            op_c     = sdiff(top_ff.val, sec_ff.val);
            op_d     = (M_W+1)'(i_ff - LEN_W'(top_ff.idx));
            lhs_in   = PROD_W'(op_a) * PROD_W'(op_b);
            rhs_in   = PROD_W'(op_c) * PROD_W'(op_d);
            state_in = B_CMP;
         end
         B_CMP: begin
            if (lhs_ff < rhs_ff && size_ff > LEN_W'(2)) begin
               size_in  = size_ff - LEN_W'(1);
               top_in   = sec_ff;
               k_raddr  = IDX_W'(size_ff - LEN_W'(3));
               state_in = B_POP;
            end else begin
               if (lhs_ff < rhs_ff) begin
                  k_we    = 1'b1;
                  k_waddr = IDX_W'(1);
                  k_wdata = cand;
                  top_in  = cand;
               end else begin
                  k_we    = 1'b1;
                  k_waddr = size_ff[IDX_W-1:0];
                  k_wdata = cand;
                  sec_in  = top_ff;
                  top_in  = cand;
                  size_in = size_ff + LEN_W'(1);
               end
               i_in     = i_ff + LEN_W'(1);
               state_in = (i_ff + LEN_W'(1) == n_ff) ? B_W0 : B_RD;
            end
         end
         B_POP: begin
            sec_in   = k_rdata_ff;
            state_in = B_MUL;
         end
         B_W0: begin
            k_raddr  = '0;
            s_raddr  = n_m1[IDX_W-1:0];
            i_in     = '0;
            p_in     = LEN_W'(1);
            state_in = B_W1;
         end
         B_W1: begin
            a_in     = k_rdata_ff;
            un1_in   = s_rdata_ff;
            k_raddr  = IDX_W'(1);
            state_in = B_W2;
         end
         B_W2: begin
            b_in     = k_rdata_ff;
            state_in = B_CHK;
         end
         B_CHK: begin
            if (p_ff < size_ff - LEN_W'(1)) begin
               op_a     = (DATA_W+1)'(odd_i);
               op_b     = (M_W+1)'(b_ff.idx - a_ff.idx);
               op_c     = sdiff(b_ff.val, a_ff.val);
               op_d     = (M_W+1)'({nsq_ff, 1'b0});
               lhs_in   = (PROD_W'(op_a) * PROD_W'(op_b)) <<< FRAC_BITS;
               rhs_in   = PROD_W'(op_c) * PROD_W'(op_d);
               state_in = B_WCMP;
            end else begin
               state_in = B_TM;
            end
         end
         B_WCMP: begin
            if (lhs_ff > rhs_ff) begin
               p_in     = p_ff + LEN_W'(1);
               k_raddr  = IDX_W'(p_ff + LEN_W'(1));
               state_in = B_ADV;
            end else begin
               state_in = B_TM;
            end
         end
         B_ADV: begin
            a_in     = b_ff;
            b_in     = k_rdata_ff;
            state_in = B_CHK;
         end
         B_TM: begin
            m_in     = M_W'(odd_i * odd_k);
            state_in = B_TG;
         end
         B_TG: begin
            div_go   = 1'b1;
            state_in = B_TW;
         end
         B_TW: begin
            if (div_done) begin
               if (!second_ff) begin
                  v1_in     = v2;
                  second_in = 1'b1;
                  state_in  = B_TM;
               end else begin
                  second_in = 1'b0;
                  if (v1_ff > v2) begin
                     vsel     = v1_ff;
                     index_in = a_ff.idx;
                  end else begin
                     index_in = n_m1[IDX_W-1:0];
                  end
                  if (vsel[DATA_W+1:DATA_W-1] == 3'b000 ||
                      vsel[DATA_W+1:DATA_W-1] == 3'b111) begin
                     value_in = vsel[DATA_W-1:0];
                  end else if (vsel[DATA_W+1]) begin
                     value_in = {1'b1, {(DATA_W-1){1'b0}}};
                  end else begin
                     value_in = {1'b0, {(DATA_W-1){1'b1}}};
                  end
                  valid_in = 1'b1;
                  last_in  = (i_ff == n_m1);
                  i_in     = i_ff + LEN_W'(1);
                  state_in = (i_ff == n_m1) ? B_IDLE : B_CHK;
               end
            end
         end
         default: state_in = B_IDLE;
      endcase

      rsp_valid          = valid_ff;
      rsp_dual_value     = value_ff;
      rsp_matching_index = index_ff;
      rsp_last_of_row    = last_ff;
   end

   always_ff @(posedge clock) begin
      if (s_we) begin
         smem[s_waddr] <= s_wdata;
      end
      s_rdata_ff <= smem[s_raddr];
   end

   always_ff @(posedge clock) begin
      if (k_we) begin
         kmem[k_waddr] <= k_wdata;
      end
      k_rdata_ff <= kmem[k_raddr];
   end

   always_ff @(posedge clock) begin
      n_ff     <= n_in;
      nsq_ff   <= nsq_in;
      i_ff     <= i_in;
      p_ff     <= p_in;
      size_ff  <= size_in;
      sec_ff   <= sec_in;
      top_ff   <= top_in;
      a_ff     <= a_in;
      b_ff     <= b_in;
      bval_ff  <= bval_in;
      un1_ff   <= un1_in;
      lhs_ff   <= lhs_in;
      rhs_ff   <= rhs_in;
      m_ff     <= m_in;
      v1_ff    <= v1_in;
      value_ff <= value_in;
      index_ff <= index_in;
      last_ff  <= last_in;
      if (reset) begin
         state_ff  <= B_IDLE;
         second_ff <= 1'b0;
         valid_ff  <= 1'b0;
      end else begin
         state_ff  <= state_in;
         second_ff <= second_in;
         valid_ff  <= valid_in;
      end
   end

endmodule
`default_nettype wire

>>> src/row_c_transform_hull.sv
// Top level of the row c-transform hull engine.
// Depends on rcth_pkg, rcth_front, rcth_queue and rcth_back.
//
// Usage:
//   Input: drive req_sample with start high; the word is taken at a clock
//   edge where busy is low. Samples of a row arrive in index order.
//   Config: csr_we with csr_wdata sets the row length n (clamped to 2..64)
//   and restarts loading at index 0. Write only while the block is idle.
//   Output: rsp_valid marks each result for exactly one cycle; the receiver
//   must take it then. One row yields n results, rsp_last_of_row on the last.
// Timing:
//   Samples are taken one per cycle into a 4-word queue; busy rises only
//   when the queue is full. The back end drains one word per cycle into the
//   sample memory while idle. After the last sample of a row it builds the
//   hull (read, load, multiply, compare per sample; a stack pop repeats the
//   multiply and compare), then walks the grid (check, compare, advance per
//   hull step) and runs two divider passes per result; it pops no words meanwhile.
// Reset:
//   Synchronous, active high; row length returns to 64, queue and counts
//   clear. The sample and hull memories are not cleared.
`timescale 1ns / 1ps
`default_nettype none
module row_c_transform_hull import rcth_pkg::*; (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              start,
   output logic                   busy,
   input  wire logic [DATA_W-1:0] req_sample,
   input  wire logic              csr_we,
   input  wire logic [LEN_W-1:0]  csr_wdata,
   output logic                   rsp_valid,
   output logic [DATA_W-1:0]      rsp_dual_value,
   output logic [IDX_W-1:0]       rsp_matching_index,
   output logic                   rsp_last_of_row
);

   word_type push_word, head;
   logic     push, pop, empty, full;

   rcth_front u_front (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .req_sample (req_sample),
      .csr_we     (csr_we),
      .csr_wdata  (csr_wdata),
      .q_full     (full),
      .busy       (busy),
      .push       (push),
      .word       (push_word)
   );

   rcth_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_word (push_word),
      .pop       (pop),
      .head      (head),
      .empty     (empty),
      .full      (full)
   );

   rcth_back u_back (
      .clock              (clock),
      .reset              (reset),
      .head               (head),
      .empty              (empty),
      .pop                (pop),
      .rsp_valid          (rsp_valid),
      .rsp_dual_value     (rsp_dual_value),
      .rsp_matching_index (rsp_matching_index),
      .rsp_last_of_row    (rsp_last_of_row)
   );

endmodule
`default_nettype wire

>>> tb/row_c_transform_hull_checker.sv
// Checker for the row c-transform hull engine: predicts each row's dual values
// and matching indexes from the accepted sample words and compares the results.
// Depends on rcth_pkg.
`timescale 1ns / 1ps
`default_nettype none
module row_c_transform_hull_checker import rcth_pkg::*; (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              start,
   input  wire logic              busy,
   input  wire logic [DATA_W-1:0] req_sample,
   input  wire logic              csr_we,
   input  wire logic [LEN_W-1:0]  csr_wdata,
   input  wire logic              rsp_valid,
   input  wire logic [DATA_W-1:0] rsp_dual_value,
   input  wire logic [IDX_W-1:0]  rsp_matching_index,
   input  wire logic              rsp_last_of_row,
   output int                     fail_count,
   output int                     pending_count
);

   typedef struct {
      logic [DATA_W-1:0] dual;
      logic [IDX_W-1:0]  idx;
      logic              last;
   } dual_word_type;

   dual_word_type dual_queue[$];
   longint        row_samples[MAX_ROW];
   int            hull_idx[MAX_ROW];
   int            row_len_reg;
   int            loaded;

   assign pending_count = dual_queue.size();

   function automatic int used_len();
      int n;
      n = row_len_reg;
      if (n < 2) n = 2;
      if (n > MAX_ROW) n = MAX_ROW;
      return n;
   endfunction

   function automatic longint grid_term(int i, int k, int n);
      longint num;
      longint den;
      num = longint'((2 * i + 1) * (2 * k + 1)) <<< FRAC_BITS;
      den = 4 * longint'(n) * n;
      return (num + den / 2) / den - row_samples[k];
   endfunction

   task automatic predict_row();
      int     n;
      int     top;
      int     cur;
      int     a;
      int     b;
      int     c;
      int     k;
      longint v1;
      longint v2;
      longint v;
      dual_word_type w;
      n = used_len();
      hull_idx[0] = 0;
      hull_idx[1] = 1;
      top = 2;
      for (int j = 2; j < n; j++) begin
         while (top >= 2) begin
            c = hull_idx[top - 2];
            a = hull_idx[top - 1];
            if ((row_samples[j] - row_samples[a]) * (a - c) <
                (row_samples[a] - row_samples[c]) * (j - a))
               top--;
            else
               break;
         end
         hull_idx[top] = j;
         top++;
      end
      cur = 1;
      for (int i = 0; i < n; i++) begin
         while (cur < top - 1) begin
            a = hull_idx[cur - 1];
            b = hull_idx[cur];
            if (longint'(2 * i + 1) * (longint'(1) <<< FRAC_BITS) * (b - a) >
                2 * longint'(n) * n * (row_samples[b] - row_samples[a]))
               cur++;
            else
               break;
         end
         k = hull_idx[cur - 1];
         v1 = grid_term(i, k, n);
         v2 = grid_term(i, n - 1, n);
         if (v1 > v2) begin
            v = v1;
         end else begin
            v = v2;
            k = n - 1;
         end
         if (v > 64'sd2147483647) v = 64'sd2147483647;
         if (v < -64'sd2147483648) v = -64'sd2147483648;
         w.dual = v[DATA_W-1:0];
         w.idx = k[IDX_W-1:0];
         w.last = (i == n - 1);
         dual_queue.push_back(w);
      end
   endtask

   always @(posedge clock) begin
      dual_word_type w;
      if (reset) begin
         row_len_reg = MAX_ROW;
         loaded = 0;
         fail_count <= 0;
         dual_queue.delete();
      end else begin
         if (csr_we) begin
            row_len_reg = csr_wdata;
            loaded = 0;
         end
         if (start && !busy) begin
            if (loaded >= used_len()) loaded = 0;
            row_samples[loaded] = longint'(signed'(req_sample));
            loaded++;
            if (loaded >= used_len()) begin
               loaded = 0;
               predict_row();
            end
         end
         if (rsp_valid) begin
            if (dual_queue.size() == 0) begin
               if (fail_count < 10)
                  $display("unexpected result word: dual %h idx %0d last %0d",
                           rsp_dual_value, rsp_matching_index, rsp_last_of_row);
               fail_count <= fail_count + 1;
            end else begin
               w = dual_queue.pop_front();
               if (w.dual !== rsp_dual_value || w.idx !== rsp_matching_index ||
                   w.last !== rsp_last_of_row) begin
                  if (fail_count < 10)
                     $display("mismatch: exp dual %h idx %0d last %0d, got %h %0d %0d",
                              w.dual, w.idx, w.last, rsp_dual_value,
                              rsp_matching_index, rsp_last_of_row);
                  fail_count <= fail_count + 1;
               end
            end
         end
      end
   end

endmodule
`default_nettype wire

>>> tb/row_c_transform_hull_tb.sv
// Testbench top for the row c-transform hull engine: drives sample words and
// row length writes; the checker predicts and compares. Depends on rcth_pkg,
// row_c_transform_hull and row_c_transform_hull_checker.
`timescale 1ns / 1ps
`default_nettype none
module row_c_transform_hull_tb;
   import rcth_pkg::*;

   logic              clock = 0;
   logic              reset = 1;
   logic              start = 0;
   logic              busy;
   logic [DATA_W-1:0] req_sample = '0;
   logic              csr_we = 0;
   logic [LEN_W-1:0]  csr_wdata = '0;
   logic              rsp_valid;
   logic [DATA_W-1:0] rsp_dual_value;
   logic [IDX_W-1:0]  rsp_matching_index;
   logic              rsp_last_of_row;
   int                fail_count;
   int                pending_count;
   int                idle_pct = 36;
   longint            cycle_count = 0;
   int                row_len_now = MAX_ROW;

   localparam longint CYCLE_LIMIT = 3000000;

   always #10 clock = ~clock;

   row_c_transform_hull dut (.*);
   row_c_transform_hull_checker chk (.*);

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("row_c_transform_hull_tb: FAIL");
         $finish;
      end
   end

   task automatic send_sample(logic [DATA_W-1:0] s);
      while ($urandom_range(99) < idle_pct) begin
         start <= 0;
         @(posedge clock);
      end
      start <= 1;
      req_sample <= s;
      @(posedge clock);
      while (busy) @(posedge clock);
   endtask

   task automatic drain();
      start <= 0;
      while (pending_count != 0) @(posedge clock);
      repeat (4000) @(posedge clock);
   endtask

   task automatic set_len(int n);
      drain();
      csr_we <= 1;
      csr_wdata <= n[LEN_W-1:0];
      @(posedge clock);
      csr_we <= 0;
      row_len_now = (n < 2) ? 2 : (n > MAX_ROW ? MAX_ROW : n);
   endtask

   function automatic logic [DATA_W-1:0] rand_sample(int mode);
      case (mode)
         0: return $urandom;
         1: return {{12{1'($urandom_range(1))}}, 20'($urandom)};
         2: return 32'($urandom_range(0, 8) * 32'h10000);
         default: return (mode & 1) ? 32'h7FFFFFFF : 32'h80000000;
      endcase
   endfunction

   task automatic send_row(int mode);
      for (int j = 0; j < row_len_now; j++)
         send_sample(mode == 4 ? ((j * j) << 12) : rand_sample(mode));
   endtask

   initial begin
      int lens[6] = '{0, 1, 2, 3, 127, 5};
      repeat (9) @(posedge clock);
      reset <= 0;
      @(posedge clock);
      // directed: extremes, clamping, short rows
      set_len(lens[1]);
      send_sample(32'h7FFFFFFF);
      send_sample(32'h80000000);
      send_sample(32'h80000000);
      send_sample(32'h7FFFFFFF);
      set_len(lens[3]);
      send_row(4);
      send_sample(32'h12345678);
      set_len(lens[5]);
      send_row(4);
      send_row(0);
      set_len(lens[4]);
      send_row(3);
      set_len(lens[0]);
      send_row(0);
      // random rows through three idling phases
      for (int ph = 0; ph < 3; ph++) begin
         idle_pct = (ph == 0) ? 36 : (ph == 1 ? 54 : 0);
         for (int r = 0; r < 8; r++) begin
            set_len((ph == 2 && r == 7) ? MAX_ROW : $urandom_range(2, 12));
            send_row($urandom_range(0, 4));
         end
      end
      drain();
      if (fail_count == 0)
         $display("row_c_transform_hull_tb: PASS");
      else
         $display("row_c_transform_hull_tb: FAIL");
      $finish;
   end

endmodule
`default_nettype wire

>>> files.f
src/rcth_pkg.sv
src/rcth_front.sv
src/rcth_queue.sv
src/rcth_div.sv
src/rcth_back.sv
src/row_c_transform_hull.sv
tb/row_c_transform_hull_checker.sv
tb/row_c_transform_hull_tb.sv
